### hw/rtl/yibd_pkg.sv
// ----------------------------------------------------------------------------
// yibd_pkg
// Shared types, register codes and lookup tables of the int8 box decoder.
// ----------------------------------------------------------------------------
package yibd_pkg;

    localparam int GRID_IDX_W = 5;
    localparam int CORNER_W   = 24;
    localparam int EDGE_MAX   = 55;
    localparam int DEQ_OFFSET = 15;
    localparam int SCORE_ELEM = 4;

    typedef enum logic [2:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_ANCHOR0_WIDTH   = 3'd1,
        REG_ANCHOR0_HEIGHT  = 3'd2,
        REG_ANCHOR1_WIDTH   = 3'd3,
        REG_ANCHOR1_HEIGHT  = 3'd4,
        REG_ANCHOR2_WIDTH   = 3'd5,
        REG_ANCHOR2_HEIGHT  = 3'd6
    } cfg_reg_t;

    typedef logic [2:0][5:0] anchor_set_t;

    typedef struct packed {
        logic [3:0][7:0]         box_bytes;
        logic signed [7:0]       score;
        logic [5:0]              cell_num;
        logic [1:0]              anchor;
        logic [GRID_IDX_W-1:0]   col;
        logic [GRID_IDX_W-1:0]   row;
    } box_src_t;

    typedef logic [255:0][7:0]  sig_rom_t;
    typedef logic [255:0][15:0] exp_rom_t;

    localparam logic [63:0] SCALE_NUM = 64'd14218327403068542;
    localparam logic [63:0] SCALE_DEN = 64'd100000000000000000;
    localparam logic [63:0] ONE_Q24   = 64'd1 << 24;

    function automatic logic [63:0] scale_q30();
        logic [63:0] r;
        logic [63:0] s;
        r = SCALE_NUM;
        s = '0;
        for (int i = 0; i < 30; i++)
        begin
            r = r << 1;
            s = s << 1;
            if (r >= SCALE_DEN)
            begin
                r = r - SCALE_DEN;
                s = s | 64'd1;
            end
        end
        return s;
    endfunction

    // restoring long division for table construction
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q24(logic [63:0] a, logic [63:0] b);
        return (a * b + (64'd1 << 23)) >> 24;
    endfunction

    // exp(+-scale) by Taylor series in Q30, rounded to Q24
    function automatic logic [63:0] exp_step_q24(logic [63:0] s30, logic negative);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 20; k++)
        begin
            term = div_u64((term * s30) >> 30, 64'(k));
            if (negative && ((k & 1) == 1))
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (sum + 64'd32) >> 6;
    endfunction

    function automatic logic [63:0] exp_neg_pow(logic [63:0] en, int m);
        logic [63:0] p;
        p = ONE_Q24;
        for (int i = 0; i < m; i++)
            p = mul_q24(p, en);
        return p;
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t    rom;
        logic [63:0] en;
        logic [63:0] p;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] s;
        int          n;
        int          m;
        en = exp_step_q24(scale_q30(), 1'b1);
        for (int b = 0; b < 256; b++)
        begin
            n   = ((b >= 128) ? b - 256 : b) + DEQ_OFFSET;
            m   = (n < 0) ? -n : n;
            p   = exp_neg_pow(en, m);
            num = (n >= 0) ? ONE_Q24 : p;
            den = ONE_Q24 + p;
            s   = div_u64(num * 64'd512 + den, 64'd2 * den);
            rom[b] = (s > 64'd255) ? 8'd255 : s[7:0];
        end
        return rom;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] s30;
        logic [63:0] ep;
        logic [63:0] en;
        logic [63:0] v;
        logic [63:0] e;
        int          n;
        int          m;
        s30 = scale_q30();
        ep  = exp_step_q24(s30, 1'b0);
        en  = exp_step_q24(s30, 1'b1);
        for (int b = 0; b < 256; b++)
        begin
            n = ((b >= 128) ? b - 256 : b) + DEQ_OFFSET;
            m = (n < 0) ? -n : n;
            if (n <= 0)
            begin
                v = exp_neg_pow(en, m);
            end
            else
            begin
                v = ONE_Q24;
                for (int i = 0; i < m; i++)
                    if (v < (64'd256 << 24))
                        v = mul_q24(v, ep);
            end
            e = (v + (64'd1 << 15)) >> 16;
            rom[b] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();
    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### hw/rtl/yibd_position.sv
// ----------------------------------------------------------------------------
// yibd_position
// Tensor position counters and held anchor bytes; flags a kept box on the
// last byte of each anchor.
// ----------------------------------------------------------------------------
module yibd_position #(
    parameter int GRID_SIDE        = 7,
    parameter int ANCHOR_COUNT     = 3,
    parameter int BYTES_PER_ANCHOR = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic signed [7:0]       tensor_byte,
    input  logic                    frame_start,
    input  logic signed [7:0]       score_threshold,
    output logic                    fire,
    output yibd_pkg::box_src_t      src
);
    import yibd_pkg::*;

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ELEM_W = $clog2(BYTES_PER_ANCHOR);

    logic [ELEM_W-1:0]     elem_reg,   elem_next,   elem_eff;
    logic [1:0]            anchor_reg, anchor_next, anchor_eff;
    logic [GRID_IDX_W-1:0] col_reg,    col_next,    col_eff;
    logic [GRID_IDX_W-1:0] row_reg,    row_next,    row_eff;
    logic [CELL_W-1:0]     cell_reg,   cell_next,   cell_eff;
    logic [3:0][7:0]       held_reg;
    logic signed [7:0]     score_reg;
    logic signed [7:0]     score_eff;
    logic                  last_elem;
    logic                  last_anchor;
    logic                  last_col;
    logic                  last_row;

    always_comb
    begin
        elem_eff   = frame_start ? '0 : elem_reg;
        anchor_eff = frame_start ? '0 : anchor_reg;
        col_eff    = frame_start ? '0 : col_reg;
        row_eff    = frame_start ? '0 : row_reg;
        cell_eff   = frame_start ? '0 : cell_reg;

        last_elem   = (elem_eff == ELEM_W'(BYTES_PER_ANCHOR - 1));
        last_anchor = (anchor_eff == 2'(ANCHOR_COUNT - 1));
        last_col    = (col_eff == GRID_IDX_W'(GRID_SIDE - 1));
        last_row    = (row_eff == GRID_IDX_W'(GRID_SIDE - 1));

        score_eff = (elem_eff == ELEM_W'(SCORE_ELEM)) ? tensor_byte : score_reg;
        fire      = last_elem && (score_eff > score_threshold);

        src.box_bytes = held_reg;
        src.score     = score_eff;
        src.cell_num  = 6'(cell_eff);
        src.anchor    = anchor_eff;
        src.col       = col_eff;
        src.row       = row_eff;

        elem_next   = elem_eff + ELEM_W'(1);
        anchor_next = anchor_eff;
        col_next    = col_eff;
        row_next    = row_eff;
        cell_next   = cell_eff;
        if (last_elem)
        begin
            elem_next   = '0;
            anchor_next = anchor_eff + 2'd1;
            if (last_anchor)
            begin
                anchor_next = '0;
                cell_next   = cell_eff + CELL_W'(1);
                col_next    = col_eff + GRID_IDX_W'(1);
                if (last_col)
                begin
                    col_next = '0;
                    row_next = row_eff + GRID_IDX_W'(1);
                    if (last_row)
                    begin
                        row_next  = '0;
                        cell_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_reg   <= '0;
            anchor_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            cell_reg   <= '0;
        end
        else if (accept)
        begin
            elem_reg   <= elem_next;
            anchor_reg <= anchor_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cell_reg   <= cell_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (elem_eff < ELEM_W'(SCORE_ELEM))
                held_reg[elem_eff[1:0]] <= tensor_byte;
            else if (elem_eff == ELEM_W'(SCORE_ELEM))
                score_reg <= tensor_byte;
        end
    end

endmodule

### hw/rtl/yibd_box_calc.sv
// ----------------------------------------------------------------------------
// yibd_box_calc
// Box geometry: sigmoid and exp lookup, prior scaling and corner clamping.
// ----------------------------------------------------------------------------
module yibd_box_calc #(
    parameter int CELL_PIXELS = 8
) (
    input  yibd_pkg::box_src_t    src,
    input  yibd_pkg::anchor_set_t prior_w,
    input  yibd_pkg::anchor_set_t prior_h,
    output logic [5:0]            left,
    output logic [5:0]            top,
    output logic [5:0]            right,
    output logic [5:0]            bottom
);
    import yibd_pkg::*;

    localparam int POS_W = 8 + GRID_IDX_W;
    localparam int CP_W  = $clog2(CELL_PIXELS + 1);
    localparam int PX_W  = POS_W + CP_W;

    function automatic logic [5:0] clamp_corner(logic signed [CORNER_W-1:0] q9);
        logic signed [CORNER_W-1:0] v;
        v = q9 >>> 9;
        if (q9 <= 0)
            return 6'd0;
        else if (v > CORNER_W'(EDGE_MAX))
            return 6'(EDGE_MAX);
        else
            return v[5:0];
    endfunction

    logic [1:0]                 a_sel;
    logic [7:0]                 sig_x, sig_y;
    logic [15:0]                exp_w, exp_h;
    logic [PX_W-1:0]            px, py;
    logic [21:0]                w, h;
    logic signed [CORNER_W-1:0] cx2, cy2, ws, hs;

    always_comb
    begin
        a_sel = (src.anchor < 2'd3) ? src.anchor : 2'd2;
        sig_x = SIG_ROM[src.box_bytes[0]];
        sig_y = SIG_ROM[src.box_bytes[1]];
        exp_w = EXP_ROM[src.box_bytes[2]];
        exp_h = EXP_ROM[src.box_bytes[3]];

        px = PX_W'({src.col, sig_x}) * PX_W'(CELL_PIXELS);
        py = PX_W'({src.row, sig_y}) * PX_W'(CELL_PIXELS);
        w  = 22'(exp_w) * 22'(prior_w[a_sel]);
        h  = 22'(exp_h) * 22'(prior_h[a_sel]);

        cx2 = CORNER_W'({px, 1'b0});
        cy2 = CORNER_W'({py, 1'b0});
        ws  = CORNER_W'(w);
        hs  = CORNER_W'(h);

        left   = clamp_corner(cx2 - ws);
        top    = clamp_corner(cy2 - hs);
        right  = clamp_corner(cx2 + ws);
        bottom = clamp_corner(cy2 + hs);
    end

endmodule

### hw/rtl/yolo_int8_box_decoder_unit.sv
// ----------------------------------------------------------------------------
// yolo_int8_box_decoder_unit
// Streaming decoder of int8 detector tensor bytes into clamped pixel boxes.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   in       | in_valid / in_ready  | tensor_byte, frame_start
//   out      | out_valid / out_ready| box corners, box_score, cell, anchor
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (write only)
//
// One tensor byte per cycle while in_ready is high. A kept box goes from the
// position stage register through the geometry stage into the output register.
// Reset restores the default threshold and priors and zeroes the position;
// no clearing pass. A stalled output holds one box and one more in the
// position stage; in_ready drops only while both are full and out is stalled.
// ----------------------------------------------------------------------------
module yolo_int8_box_decoder_unit #(
    parameter int GRID_SIDE        = 7,
    parameter int CELL_PIXELS      = 8,
    parameter int ANCHOR_COUNT     = 3,
    parameter int BYTES_PER_ANCHOR = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic signed [7:0] tensor_byte,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [5:0]        box_left,
    output logic [5:0]        box_top,
    output logic [5:0]        box_right,
    output logic [5:0]        box_bottom,
    output logic signed [7:0] box_score,
    output logic [5:0]        cell_index,
    output logic [1:0]        anchor_index,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import yibd_pkg::*;

    logic signed [7:0] thr_reg;
    anchor_set_t       prior_w_reg;
    anchor_set_t       prior_h_reg;

    logic              in_accept;
    logic              fire;
    box_src_t          src;
    logic              s1_valid_reg, s1_valid_next;
    box_src_t          s1_reg;
    logic              s1_advance;
    logic              out_valid_next;
    logic [5:0]        calc_left, calc_top, calc_right, calc_bottom;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= -8'sd16;
            prior_w_reg <= {6'd22, 6'd12, 6'd9};
            prior_h_reg <= {6'd21, 6'd17, 6'd14};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCORE_THRESHOLD: thr_reg        <= cfg_data;
                REG_ANCHOR0_WIDTH:   prior_w_reg[0] <= cfg_data[5:0];
                REG_ANCHOR0_HEIGHT:  prior_h_reg[0] <= cfg_data[5:0];
                REG_ANCHOR1_WIDTH:   prior_w_reg[1] <= cfg_data[5:0];
                REG_ANCHOR1_HEIGHT:  prior_h_reg[1] <= cfg_data[5:0];
                REG_ANCHOR2_WIDTH:   prior_w_reg[2] <= cfg_data[5:0];
                REG_ANCHOR2_HEIGHT:  prior_h_reg[2] <= cfg_data[5:0];
                default:             ;
            endcase
        end
    end

    assign s1_advance = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid || out_ready;
    assign in_accept  = in_valid && in_ready;

    yibd_position #(
        .GRID_SIDE        (GRID_SIDE),
        .ANCHOR_COUNT     (ANCHOR_COUNT),
        .BYTES_PER_ANCHOR (BYTES_PER_ANCHOR)
    ) u_position (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .tensor_byte     (tensor_byte),
        .frame_start     (frame_start),
        .score_threshold (thr_reg),
        .fire            (fire),
        .src             (src)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = fire;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && fire)
            s1_reg <= src;
    end

    yibd_box_calc #(
        .CELL_PIXELS (CELL_PIXELS)
    ) u_box_calc (
        .src     (s1_reg),
        .prior_w (prior_w_reg),
        .prior_h (prior_h_reg),
        .left    (calc_left),
        .top     (calc_top),
        .right   (calc_right),
        .bottom  (calc_bottom)
    );

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            box_left     <= calc_left;
            box_top      <= calc_top;
            box_right    <= calc_right;
            box_bottom   <= calc_bottom;
            box_score    <= s1_reg.score;
            cell_index   <= s1_reg.cell_num;
            anchor_index <= s1_reg.anchor;
        end
    end

endmodule

### hw/rtl/yibd_checker.sv
// ----------------------------------------------------------------------------
// yibd_checker
// Port-level checks of the box decoder, bound to the top level.
// ----------------------------------------------------------------------------
module yibd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [5:0]        box_left,
    input logic [5:0]        box_top,
    input logic [5:0]        box_right,
    input logic [5:0]        box_bottom,
    input logic signed [7:0] box_score,
    input logic [1:0]        anchor_index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(box_left) && $stable(box_right)
            && $stable(box_top) && $stable(box_bottom) && $stable(box_score))
        else $error("output beat changed while stalled");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> box_left <= box_right && box_top <= box_bottom)
        else $error("box corners out of order");

    a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> box_right <= 6'd55 && box_bottom <= 6'd55 && anchor_index != 2'd3)
        else $error("box corner or anchor out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("box appeared without an input beat two cycles before");

endmodule

bind yolo_int8_box_decoder_unit yibd_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .box_left     (box_left),
    .box_top      (box_top),
    .box_right    (box_right),
    .box_bottom   (box_bottom),
    .box_score    (box_score),
    .anchor_index (anchor_index)
);
